/* hw/rtl/kspm_pkg.sv */
// ----------------------------------------------------------------------------
// kspm_pkg
// Shared types and constants of the key sequence prefix matcher.
// ----------------------------------------------------------------------------
package kspm_pkg;

  localparam int TableEntriesDefault = 64;
  localparam int SeqKeysDefault      = 8;
  localparam int KeyBitsDefault      = 32;

  localparam int LenBits  = 4;
  localparam int CodeBits = 16;
  localparam int CfgBits  = 32;

  localparam logic [CfgBits-1:0] StripMaskReset = 32'h0000_00FF;

  typedef enum logic [1:0] {
    REQ_KEY_WR = 2'd0,
    REQ_HDR_WR = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_KEY    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_MORE     = 2'd0,
    ST_MATCH    = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_STRICT     = 2'd0,
    CFG_STRIP_MASK = 2'd1,
    CFG_IGN_MASK   = 2'd2,
    CFG_ENTRY_CNT  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WALK = 1'b1
  } fsm_e;

  // Candidate entry as it travels down the row of cells.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                ok;
    logic [LenBits-1:0]  len;
    logic [CodeBits-1:0] code;
  } token_t;

endpackage

/* hw/rtl/key_sequence_prefix_matcher_core.sv */
// ----------------------------------------------------------------------------
// key_sequence_prefix_matcher_core
// Matches a typed multi-key shortcut against a loaded table of key sequences.
// ----------------------------------------------------------------------------
// Load and clear items give no result. A key item walks the active entries,
// the first min(entry_count, TABLE_ENTRIES), in index order, issuing one
// entry per cycle into a row of SEQ_KEYS cells, each cell checking one key
// position. On overflow or with no active entries it gives its result
// without a walk; the walk stops at the first deciding entry. The result
// appears on done_o for one cycle and cannot be stalled; busy is high while
// a key item walks the table.
module key_sequence_prefix_matcher_core #(
  parameter int TABLE_ENTRIES = kspm_pkg::TableEntriesDefault,
  parameter int SEQ_KEYS      = kspm_pkg::SeqKeysDefault,
  parameter int KEY_BITS      = kspm_pkg::KeyBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [5:0]                    entry_index_i,
  input  logic [2:0]                    key_position_i,
  input  logic [KEY_BITS-1:0]           key_value_i,
  input  logic [kspm_pkg::LenBits-1:0]  entry_length_i,
  input  logic [kspm_pkg::CodeBits-1:0] entry_code_i,
  output logic                          done_o,
  output logic [1:0]                    match_status_o,
  output logic [kspm_pkg::CodeBits-1:0] command_code_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [kspm_pkg::CfgBits-1:0]  cfg_data_i
);

  localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW    = $clog2(SEQ_KEYS + 1);
  localparam int LW    = $clog2(TABLE_ENTRIES + 1);
  localparam int HdrW  = kspm_pkg::LenBits + kspm_pkg::CodeBits;
  localparam int CmpW  = (CW > kspm_pkg::LenBits) ? CW : kspm_pkg::LenBits;

  // Configuration registers.
  logic                         strict_q;
  logic [kspm_pkg::CfgBits-1:0] strip_q, ign_q;
  logic [6:0]                   ecnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      strip_q  <= kspm_pkg::StripMaskReset;
      ign_q    <= '0;
      ecnt_q   <= '0;
    end else if (cfg_valid_i) begin
      case (kspm_pkg::cfg_idx_e'(cfg_index_i))
        kspm_pkg::CFG_STRICT:     strict_q <= cfg_data_i[0];
        kspm_pkg::CFG_STRIP_MASK: strip_q  <= cfg_data_i;
        kspm_pkg::CFG_IGN_MASK:   ign_q    <= cfg_data_i;
        kspm_pkg::CFG_ENTRY_CNT:  ecnt_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Item decode.
  logic accept, is_key_wr, is_hdr_wr, is_clear, is_key, idx_ok, full;
  logic [AW-1:0] waddr;
  logic [CW-1:0] count_q;
  logic [LW-1:0] limit;

  assign accept    = start & ~busy;
  assign is_key_wr = accept & (req_type_i == kspm_pkg::REQ_KEY_WR);
  assign is_hdr_wr = accept & (req_type_i == kspm_pkg::REQ_HDR_WR);
  assign is_clear  = accept & (req_type_i == kspm_pkg::REQ_CLEAR);
  assign is_key    = accept & (req_type_i == kspm_pkg::REQ_KEY);
  assign idx_ok    = int'(entry_index_i) < TABLE_ENTRIES;
  assign waddr     = AW'(entry_index_i);
  assign full      = (count_q == CW'(SEQ_KEYS));
  assign limit     = (int'(ecnt_q) < TABLE_ENTRIES) ? LW'(ecnt_q) : LW'(TABLE_ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (is_clear) begin
      count_q <= '0;
    end else if (is_key && !full) begin
      count_q <= count_q + CW'(1);
    end
  end

  // Walk control.
  kspm_pkg::fsm_e   fsm_q, fsm_d;
  logic [LW-1:0]    cnt_q, cnt_d, limit_q, limit_d;
  logic             iss_v_q, iss_v_d, iss_last_q, iss_last_d;
  logic [AW-1:0]    iss_idx_q, hdr_addr;
  logic [HdrW-1:0]  hdr_rdata;
  logic             flush;
  logic             res_v_d, res_v_q;
  logic [1:0]       res_st_d, res_st_q;
  logic [kspm_pkg::CodeBits-1:0] res_code_d, res_code_q;

  kspm_pkg::token_t tok   [SEQ_KEYS+1];
  logic [AW-1:0]    tok_idx [SEQ_KEYS+1];
  kspm_pkg::token_t tail;

  assign tail = tok[SEQ_KEYS];
  assign busy = (fsm_q != kspm_pkg::FSM_IDLE);

  always_comb begin
    fsm_d      = fsm_q;
    cnt_d      = cnt_q;
    limit_d    = limit_q;
    iss_v_d    = 1'b0;
    iss_last_d = 1'b0;
    flush      = 1'b0;
    res_v_d    = 1'b0;
    res_st_d   = kspm_pkg::ST_NO_MATCH;
    res_code_d = '0;
    case (fsm_q)
      kspm_pkg::FSM_IDLE: begin
        if (is_key) begin
          if (full) begin
            res_v_d  = 1'b1;
            res_st_d = kspm_pkg::ST_OVERFLOW;
          end else if (limit == '0) begin
            res_v_d  = 1'b1;
          end else begin
            fsm_d   = kspm_pkg::FSM_WALK;
            cnt_d   = '0;
            limit_d = limit;
          end
        end
      end
      kspm_pkg::FSM_WALK: begin
        if (cnt_q < limit_q) begin
          iss_v_d    = 1'b1;
          iss_last_d = (cnt_q == limit_q - LW'(1));
          cnt_d      = cnt_q + LW'(1);
        end
        if (tail.valid && tail.ok) begin
          // The first covering entry decides; equal length means a full match.
          res_v_d = 1'b1;
          if (CmpW'(tail.len) == CmpW'(count_q)) begin
            res_st_d   = kspm_pkg::ST_MATCH;
            res_code_d = tail.code;
          end else begin
            res_st_d   = kspm_pkg::ST_MORE;
          end
          flush   = 1'b1;
          iss_v_d = 1'b0;
          fsm_d   = kspm_pkg::FSM_IDLE;
        end else if (tail.valid && tail.last) begin
          res_v_d = 1'b1;
          flush   = 1'b1;
          iss_v_d = 1'b0;
          fsm_d   = kspm_pkg::FSM_IDLE;
        end
      end
      default: fsm_d = kspm_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= kspm_pkg::FSM_IDLE;
      cnt_q      <= '0;
      limit_q    <= '0;
      iss_v_q    <= 1'b0;
      iss_last_q <= 1'b0;
      res_v_q    <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      cnt_q      <= cnt_d;
      limit_q    <= limit_d;
      iss_v_q    <= iss_v_d;
      iss_last_q <= iss_last_d;
      res_v_q    <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q  <= cnt_q[AW-1:0];
    res_st_q   <= res_st_d;
    res_code_q <= res_code_d;
  end

  assign done_o         = res_v_q;
  assign match_status_o = res_st_q;
  assign command_code_o = res_code_q;

  // Entry headers: length and code, read as the entry is issued.
  assign hdr_addr = is_hdr_wr ? waddr : cnt_q[AW-1:0];

  kspm_ram #(.Width(HdrW), .Depth(1 << AW)) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (is_hdr_wr & idx_ok),
    .addr_i (hdr_addr),
    .wdata_i({entry_length_i, entry_code_i}),
    .rdata_o(hdr_rdata)
  );

  // An entry shorter than the collected sequence can never cover it.
  always_comb begin
    tok[0].valid = iss_v_q & ~flush;
    tok[0].last  = iss_last_q;
    tok[0].len   = hdr_rdata[HdrW-1 -: kspm_pkg::LenBits];
    tok[0].code  = hdr_rdata[kspm_pkg::CodeBits-1:0];
    tok[0].ok    = CmpW'(hdr_rdata[HdrW-1 -: kspm_pkg::LenBits]) >= CmpW'(count_q);
  end
  assign tok_idx[0] = iss_idx_q;

  logic [KEY_BITS-1:0] stripped;
  assign stripped = key_value_i & ~strip_q[KEY_BITS-1:0];

  for (genvar i = 0; i < SEQ_KEYS; i++) begin : g_cell
    kspm_cell #(
      .KeyBits (KEY_BITS),
      .AddrBits(AW),
      .CntBits (CW),
      .Pos     (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tbl_we_i   (is_key_wr & idx_ok & (int'(key_position_i) == i)),
      .tbl_waddr_i(waddr),
      .tbl_wdata_i(key_value_i),
      .typed_we_i (is_key & ~full & (count_q == CW'(i))),
      .typed_key_i(stripped),
      .count_i    (count_q),
      .strict_i   (strict_q),
      .ign_mask_i (ign_q[KEY_BITS-1:0]),
      .flush_i    (flush),
      .tok_i      (tok[i]),
      .idx_i      (tok_idx[i]),
      .tok_o      (tok[i+1]),
      .idx_o      (tok_idx[i+1])
    );
  end

endmodule

/* hw/rtl/kspm_ram.sv */
// ----------------------------------------------------------------------------
// kspm_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module kspm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [Width-1:0]    wdata_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/kspm_cell.sv */
// ----------------------------------------------------------------------------
// kspm_cell
// One key position: owns that position's column of table keys and the typed
// key, and checks each passing entry against it.
// ----------------------------------------------------------------------------
module kspm_cell #(
  parameter int KeyBits  = 32,
  parameter int AddrBits = 6,
  parameter int CntBits  = 4,
  parameter int Pos      = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tbl_we_i,
  input  logic [AddrBits-1:0] tbl_waddr_i,
  input  logic [KeyBits-1:0]  tbl_wdata_i,
  input  logic                typed_we_i,
  input  logic [KeyBits-1:0]  typed_key_i,
  input  logic [CntBits-1:0]  count_i,
  input  logic                strict_i,
  input  logic [KeyBits-1:0]  ign_mask_i,
  input  logic                flush_i,
  input  kspm_pkg::token_t    tok_i,
  input  logic [AddrBits-1:0] idx_i,
  output kspm_pkg::token_t    tok_o,
  output logic [AddrBits-1:0] idx_o
);

  logic [KeyBits-1:0]  typed_q;
  logic [KeyBits-1:0]  rdata;
  logic [AddrBits-1:0] ram_addr;
  kspm_pkg::token_t    tok_a_q, tok_b_q, tok_b_d;
  logic [AddrBits-1:0] idx_a_q, idx_b_q;
  logic                eq;

  assign ram_addr = tbl_we_i ? tbl_waddr_i : idx_i;

  kspm_ram #(.Width(KeyBits), .Depth(1 << AddrBits)) u_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we_i),
    .addr_i (ram_addr),
    .wdata_i(tbl_wdata_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (typed_we_i) begin
      typed_q <= typed_key_i;
    end
  end

  // Position 0 is always exact; later positions may drop modifier bits.
  always_comb begin
    if (Pos == 0 || strict_i) begin
      eq = (rdata == typed_q);
    end else begin
      eq = (((rdata ^ typed_q) & ~ign_mask_i) == '0);
    end
    tok_b_d    = tok_a_q;
    tok_b_d.ok = tok_a_q.ok & ((CntBits'(Pos) >= count_i) | eq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
    end else if (flush_i) begin
      tok_a_q <= '0;
      tok_b_q <= '0;
    end else begin
      tok_a_q <= tok_i;
      tok_b_q <= tok_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q <= idx_i;
    idx_b_q <= idx_a_q;
  end

  assign tok_o = tok_b_q;
  assign idx_o = idx_b_q;

endmodule
